FILE: rtl/idle_slideshow_sequencer_core_defines.svh
// Assertion macros for the idle slideshow sequencer checker.
// Used by iss_checker.sv; expects clk_i and rst_ni in scope.
`ifndef IDLE_SLIDESHOW_SEQUENCER_CORE_DEFINES_SVH
`define IDLE_SLIDESHOW_SEQUENCER_CORE_DEFINES_SVH

// same-cycle implication
`define ISS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ISS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/iss_pkg.sv
// Shared types and constants for the idle slideshow sequencer.
// No dependencies.
package iss_pkg;

  localparam int unsigned TIME_W    = 48;
  localparam int unsigned MS_W      = 32;
  localparam int unsigned COUNT_W   = 4;
  localparam int unsigned RAW_W     = COUNT_W + 1;
  localparam int unsigned SLIDE_W   = 3;
  localparam int unsigned ALPHA_W   = 8;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned DIV_STEPS = ALPHA_W;
  localparam int unsigned DIV_CNT_W = 4;

  localparam logic [MS_W-1:0]    IDLE_MS_RST     = 32'd60000;
  localparam logic [MS_W-1:0]    FADE_MS_RST     = 32'd500;
  localparam logic [COUNT_W-1:0] SLIDE_COUNT_RST = 4'd0;

  typedef enum logic [2:0] {
    OP_TICK     = 3'd0,
    OP_ACTIVITY = 3'd1,
    OP_NEXT     = 3'd2,
    OP_PREV     = 3'd3,
    OP_PAUSE    = 3'd4,
    OP_LOAD     = 3'd5
  } iss_op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IDLE_MS     = 2'd0,
    CFG_FADE_MS     = 2'd1,
    CFG_SLIDE_COUNT = 2'd2
  } iss_cfg_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD,
    S_UPD,
    S_WRAP,
    S_TIME,
    S_NUM,
    S_NUM2,
    S_DSTART,
    S_DIV,
    S_OUT
  } iss_state_e;

  typedef struct packed {
    logic               done;
    logic [ALPHA_W-1:0] quot;
  } iss_div_res_t;

endpackage

FILE: rtl/iss_dur_ram.sv
// Slide duration memory: one write port, one registered read port.
// Depends on iss_pkg for the data width.
module iss_dur_ram
  import iss_pkg::*;
#(
  parameter int unsigned DEPTH = 8,
  parameter int unsigned AW    = 3
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [AW-1:0]   waddr_i,
  input  logic [MS_W-1:0] wdata_i,
  input  logic            re_i,
  input  logic [AW-1:0]   raddr_i,
  output logic [MS_W-1:0] rdata_o
);

  logic [MS_W-1:0] mem [DEPTH];
  logic [MS_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/iss_alpha_div.sv
// Serial restoring divider for the dim alpha: floor(255*x/f), one quotient bit per cycle.
// Depends on iss_pkg; requires x <= f and f held stable while busy.
module iss_alpha_div
  import iss_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [MS_W-1:0] x_i,
  input  logic [MS_W-1:0] f_i,
  output iss_div_res_t    res_o
);

  localparam int unsigned PROD_W = MS_W + ALPHA_W;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [MS_W-1:0]      rem_q, rem_d;
  logic [ALPHA_W-1:0]   low_q, low_d;
  logic [ALPHA_W-1:0]   quot_q, quot_d;

  logic [PROD_W-1:0]    prod;
  logic [MS_W:0]        trial;
  logic [MS_W:0]        diff;
  logic                 ge;

  assign prod  = {x_i, {ALPHA_W{1'b0}}} - PROD_W'(x_i);
  assign trial = {rem_q, low_q[ALPHA_W-1]};
  assign diff  = trial - {1'b0, f_i};
  assign ge    = trial >= {1'b0, f_i};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    low_d  = low_q;
    quot_d = quot_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CNT_W'(DIV_STEPS);
      rem_d  = prod[PROD_W-1:ALPHA_W];
      low_d  = prod[ALPHA_W-1:0];
      quot_d = '0;
    end else if (busy_q) begin
      rem_d  = ge ? diff[MS_W-1:0] : trial[MS_W-1:0];
      low_d  = {low_q[ALPHA_W-2:0], 1'b0};
      quot_d = {quot_q[ALPHA_W-2:0], ge};
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    low_q  <= low_d;
    quot_q <= quot_d;
  end

  assign res_o.done = done_q;
  assign res_o.quot = quot_q;

endmodule

FILE: rtl/idle_slideshow_sequencer_core.sv
// Idle slideshow sequencer, top level.
// Depends on iss_pkg, iss_dur_ram and iss_alpha_div.
//
// Input channel (in_valid_i/in_ready_o) carries one event per transfer: tick,
// activity, next, previous, pause toggle or duration load. Each event gives
// exactly one result on the output channel (out_valid_o/out_ready_i) with
// visibility, slide index, pause flag and dim alpha.
// Configuration (cfg_valid_i/cfg_ready_o) writes idle_ms, fade_ms or
// slide_count by index; cfg_ready_o is always high. Write only while idle.
// Sequence: after the input transfer an event passes the states RD, UPD,
// WRAP while the slide index wraps (one subtract of the slide count per
// cycle), TIME, NUM, NUM2, DSTART, DIV and OUT, where the result is
// registered. The alpha divider gives one quotient bit per cycle.
// Throughput: one event at a time, taken the cycle after the result is set.
// Reset: defaults (idle 60000 ms, fade 500 ms, no slides), show hidden at
// slide 0. The duration table is not cleared; load an entry before it is shown.
// Stall: the result register holds while out_ready_i is low; the next event
// may be taken, but its result waits until the held one has transferred.
module idle_slideshow_sequencer_core
  import iss_pkg::*;
#(
  parameter int unsigned MAX_SLIDES = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [MS_W-1:0]      cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [2:0]           op_i,
  input  logic                 attract_i,
  input  logic [TIME_W-1:0]    now_ms_i,
  input  logic [SLIDE_W-1:0]   slide_number_i,
  input  logic [MS_W-1:0]      duration_value_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 visible_o,
  output logic [SLIDE_W-1:0]   current_slide_o,
  output logic                 held_o,
  output logic [ALPHA_W-1:0]   dim_alpha_o
);

  localparam int unsigned PTR_W = (MAX_SLIDES > 1) ? $clog2(MAX_SLIDES) : 1;

  iss_state_e state_q, state_d;

  // configuration
  logic [MS_W-1:0]    idle_ms_q, fade_ms_q;
  logic [COUNT_W-1:0] slide_count_q;
  logic [COUNT_W-1:0] n_act;

  // captured event
  iss_op_e            op_q;
  logic               attract_q;
  logic [TIME_W-1:0]  now_q;
  logic [SLIDE_W-1:0] num_q;
  logic [MS_W-1:0]    dur_q;

  // sequencer state
  logic               shown_q, shown_d;
  logic               paused_q, paused_d;
  logic               running_q, running_d;
  logic [PTR_W-1:0]   ptr_q, ptr_d;
  logic [TIME_W-1:0]  last_act_q, last_act_d;
  logic [TIME_W-1:0]  start_q, start_d;

  // work registers
  logic [TIME_W-1:0]  dact_q, dslide_q, t_q;
  logic [RAW_W-1:0]   raw_q, raw_d;
  logic [MS_W-1:0]    ax_q, bx_q, r_q;
  logic               bok_q;
  logic               need_wrap, wrap_done;
  logic [MS_W-1:0]    div_x;

  // result register
  logic               out_valid_q;
  logic               vis_q, held_q;
  logic [SLIDE_W-1:0] cur_q;
  logic [ALPHA_W-1:0] alpha_q;

  // memory and divider
  logic               ram_we, ram_re;
  logic [PTR_W-1:0]   ram_waddr, ram_raddr;
  logic [MS_W-1:0]    ram_rdata;
  logic               div_start;
  iss_div_res_t       div_res;
  logic               in_xfer, out_free, out_load;

  assign cfg_ready_o = 1'b1;
  assign in_xfer     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;

  assign n_act = (32'(slide_count_q) > 32'(MAX_SLIDES)) ? COUNT_W'(MAX_SLIDES)
                                                        : slide_count_q;

  assign wrap_done = raw_q < {1'b0, n_act};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_ms_q     <= IDLE_MS_RST;
      fade_ms_q     <= FADE_MS_RST;
      slide_count_q <= SLIDE_COUNT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (iss_cfg_e'(cfg_index_i))
        CFG_IDLE_MS:     idle_ms_q     <= cfg_data_i;
        CFG_FADE_MS:     fade_ms_q     <= cfg_data_i;
        CFG_SLIDE_COUNT: slide_count_q <= cfg_data_i[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (in_valid_i) state_d = S_RD;
      S_RD:     state_d = S_UPD;
      S_UPD:    state_d = need_wrap ? S_WRAP : S_TIME;
      S_WRAP:   if (wrap_done) state_d = S_TIME;
      S_TIME:   state_d = S_NUM;
      S_NUM:    state_d = S_NUM2;
      S_NUM2:   state_d = S_DSTART;
      S_DSTART: state_d = S_DIV;
      S_DIV:    if (div_res.done) state_d = S_OUT;
      S_OUT:    if (out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    in_ready_o = 1'b0;
    ram_re     = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      S_IDLE:   begin
        in_ready_o = 1'b1;
        ram_re     = in_valid_i;
      end
      S_UPD:    ram_re = !need_wrap;
      S_WRAP:   ram_re = wrap_done;
      S_DSTART: div_start = 1'b1;
      S_OUT:    out_load = out_free;
      default: ;
    endcase
  end

  always_comb begin
    case (state_q)
      S_WRAP:  ram_raddr = PTR_W'(raw_q);
      S_UPD:   ram_raddr = ptr_d;
      default: ram_raddr = ptr_q;
    endcase
  end

  assign ram_we    = (state_q == S_UPD) && (op_q == OP_LOAD) &&
                     (32'(num_q) < 32'(MAX_SLIDES));
  assign ram_waddr = PTR_W'(num_q);

  // state update
  always_comb begin
    shown_d    = shown_q;
    paused_d   = paused_q;
    running_d  = running_q;
    ptr_d      = ptr_q;
    last_act_d = last_act_q;
    start_d    = start_q;
    raw_d      = raw_q;
    need_wrap  = 1'b0;
    if (state_q == S_UPD) begin
      case (op_q)
        OP_TICK: begin
          if (!attract_q) begin
            running_d  = 1'b1;
            last_act_d = now_q;
            shown_d    = 1'b0;
            ptr_d      = '0;
            paused_d   = 1'b0;
          end else if (n_act != '0) begin
            if (!running_q) begin
              running_d  = 1'b1;
              last_act_d = now_q;
            end else if (!shown_q) begin
              if (dact_q >= TIME_W'(idle_ms_q)) begin
                shown_d = 1'b1;
                ptr_d   = '0;
                start_d = now_q;
              end
            end else if (!paused_q) begin
              if (dslide_q >= TIME_W'(ram_rdata)) begin
                raw_d     = RAW_W'(ptr_q) + RAW_W'(1);
                need_wrap = 1'b1;
                start_d   = now_q;
              end
            end
          end
        end
        OP_ACTIVITY: begin
          running_d  = 1'b1;
          last_act_d = now_q;
          if (shown_q) begin
            shown_d  = 1'b0;
            ptr_d    = '0;
            paused_d = 1'b0;
          end
        end
        OP_NEXT, OP_PREV: begin
          if (n_act != '0) begin
            running_d = 1'b1;
            shown_d   = 1'b1;
            start_d   = now_q;
            if (shown_q) begin
              raw_d     = (op_q == OP_NEXT) ? RAW_W'(ptr_q) + RAW_W'(1)
                                            : RAW_W'(ptr_q) + RAW_W'(n_act) - RAW_W'(1);
              need_wrap = 1'b1;
            end else begin
              ptr_d = '0;
            end
          end
        end
        OP_PAUSE: begin
          if (shown_q) paused_d = !paused_q;
        end
        OP_LOAD: begin
          ptr_d   = '0;
          shown_d = 1'b0;
        end
        default: ;
      endcase
    end else if (state_q == S_WRAP) begin
      if (wrap_done) begin
        ptr_d = PTR_W'(raw_q);
      end else begin
        raw_d = raw_q - RAW_W'(n_act);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      shown_q     <= 1'b0;
      paused_q    <= 1'b0;
      running_q   <= 1'b0;
      ptr_q       <= '0;
      last_act_q  <= '0;
      start_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      shown_q    <= shown_d;
      paused_q   <= paused_d;
      running_q  <= running_d;
      ptr_q      <= ptr_d;
      last_act_q <= last_act_d;
      start_q    <= start_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload and work registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q      <= iss_op_e'(op_i);
      attract_q <= attract_i;
      now_q     <= now_ms_i;
      num_q     <= slide_number_i;
      dur_q     <= duration_value_i;
    end
    raw_q <= raw_d;
    if (state_q == S_RD) begin
      dact_q   <= now_q - last_act_q;
      dslide_q <= now_q - start_q;
    end
    if (state_q == S_TIME) begin
      t_q <= now_q - start_q;
    end
    if (state_q == S_NUM) begin
      ax_q  <= (t_q < TIME_W'(fade_ms_q)) ? fade_ms_q - t_q[MS_W-1:0] : '0;
      bok_q <= !paused_q && (ram_rdata != '0) && (t_q < TIME_W'(ram_rdata));
      r_q   <= ram_rdata - t_q[MS_W-1:0];
    end
    if (state_q == S_NUM2) begin
      bx_q <= (bok_q && (r_q < fade_ms_q)) ? fade_ms_q - r_q : '0;
    end
    if (out_load) begin
      vis_q   <= shown_q;
      cur_q   <= SLIDE_W'(ptr_q);
      held_q  <= paused_q;
      alpha_q <= (shown_q && (fade_ms_q != '0)) ? div_res.quot : '0;
    end
  end

  assign div_x = (ax_q > bx_q) ? ax_q : bx_q;

  iss_dur_ram #(
    .DEPTH (MAX_SLIDES),
    .AW    (PTR_W)
  ) u_dur_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (dur_q),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  iss_alpha_div u_alpha_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .x_i     (div_x),
    .f_i     (fade_ms_q),
    .res_o   (div_res)
  );

  assign out_valid_o     = out_valid_q;
  assign visible_o       = vis_q;
  assign current_slide_o = cur_q;
  assign held_o          = held_q;
  assign dim_alpha_o     = alpha_q;

endmodule

FILE: rtl/iss_checker.sv
// Port-level checks for the idle slideshow sequencer, bound to the top level.
// Depends on iss_pkg and idle_slideshow_sequencer_core_defines.svh.
`include "idle_slideshow_sequencer_core_defines.svh"

module iss_checker
  import iss_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic               visible_o,
  input logic [SLIDE_W-1:0] current_slide_o,
  input logic               held_o,
  input logic [ALPHA_W-1:0] dim_alpha_o
);

  // hidden show never dims
  `ISS_ASSERT_NOW(a_hidden_alpha, out_valid_o && !visible_o, dim_alpha_o == '0, "alpha set while hidden")

  // every hide path rewinds to slide 0
  `ISS_ASSERT_NOW(a_hidden_slide, out_valid_o && !visible_o, current_slide_o == '0, "hidden with nonzero slide")

  // one event in flight: no transfer right after a transfer
  `ISS_ASSERT_NEXT(a_one_inflight, in_valid_i && in_ready_o, !in_ready_o, "input ready right after a transfer")

  // stalled result holds
  `ISS_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(visible_o) && $stable(current_slide_o) && $stable(held_o) && $stable(dim_alpha_o), "stalled result changed")

endmodule

bind idle_slideshow_sequencer_core iss_checker u_iss_checker (.*);

FILE: bench/testbench.sv
// Testbench for idle_slideshow_sequencer_core: directed and random events with random stalls.
// A scoreboard class predicts every result and checks the output channel field by field.
// Depends on iss_pkg and the core RTL.
module testbench;
  import iss_pkg::*;

  localparam logic [2:0]  OP_SPARE_A      = 3'd6;
  localparam logic [2:0]  OP_SPARE_B      = 3'd7;
  localparam int unsigned TABLE_SIZE      = 8;
  localparam int unsigned PHASE_COUNT     = 8;
  localparam int unsigned ITEMS_PER_PHASE = 140;
  localparam int unsigned HOLDOFF_CYCLES  = 400;
  localparam int unsigned REPORT_CAP      = 200;
  localparam logic [TIME_W-1:0] WRAP_BASE = 48'hFFFF_FFFF_FFF0;

  typedef struct packed {
    logic [2:0]         op;
    logic               attract;
    logic [TIME_W-1:0]  now;
    logic [SLIDE_W-1:0] num;
    logic [MS_W-1:0]    dur;
  } slide_event_t;

  typedef struct packed {
    logic               visible;
    logic [SLIDE_W-1:0] slide;
    logic               held;
    logic [ALPHA_W-1:0] alpha;
  } slide_view_t;

  class slideshow_scoreboard;
    logic [MS_W-1:0]    idle_ms = IDLE_MS_RST;
    logic [MS_W-1:0]    fade_ms = FADE_MS_RST;
    logic [COUNT_W-1:0] slide_count = SLIDE_COUNT_RST;
    bit                 shown;
    bit                 paused;
    bit                 running;
    logic [SLIDE_W-1:0] pointer = '0;
    logic [TIME_W-1:0]  quiet_since = '0;
    logic [TIME_W-1:0]  slide_since = '0;
    logic [MS_W-1:0]    durations [TABLE_SIZE];
    slide_view_t        views_due [$];
    int unsigned        mismatches;

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [MS_W-1:0] data);
      case (idx)
        CFG_IDLE_MS:     idle_ms = data;
        CFG_FADE_MS:     fade_ms = data;
        CFG_SLIDE_COUNT: slide_count = data[COUNT_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned live_slides();
      return (slide_count > TABLE_SIZE) ? TABLE_SIZE : slide_count;
    endfunction

    function void show_slide(int unsigned idx, logic [TIME_W-1:0] now);
      running = 1'b1;
      shown = 1'b1;
      pointer = SLIDE_W'(idx);
      slide_since = now;
    endfunction

    function void go_dark(logic [TIME_W-1:0] now);
      running = 1'b1;
      quiet_since = now;
      shown = 1'b0;
      pointer = '0;
      paused = 1'b0;
    endfunction

    function logic [ALPHA_W-1:0] dim_level(logic [TIME_W-1:0] now);
      logic [TIME_W-1:0] age;
      logic [63:0] f, t, d, r, a, b;
      if (!shown || fade_ms == 0) return '0;
      age = now - slide_since;
      f = 64'(fade_ms);
      t = 64'(age);
      a = 0;
      if (t < f) a = (64'd255 * (f - t)) / f;
      d = 64'(durations[pointer]);
      if (!paused && d > 0 && t < d) begin
        r = d - t;
        if (r < f) begin
          b = (64'd255 * (f - r)) / f;
          if (b > a) a = b;
        end
      end
      return a[ALPHA_W-1:0];
    endfunction

    function void advance_clock(logic attract, logic [TIME_W-1:0] now);
      int unsigned n;
      logic [TIME_W-1:0] quiet, age;
      n = live_slides();
      if (!attract) begin
        go_dark(now);
        return;
      end
      if (n == 0) return;
      if (!running) begin
        running = 1'b1;
        quiet_since = now;
        return;
      end
      if (!shown) begin
        quiet = now - quiet_since;
        if (quiet >= idle_ms) show_slide(0, now);
        return;
      end
      if (paused) return;
      age = now - slide_since;
      if (age >= durations[pointer]) begin
        pointer = SLIDE_W'((pointer + 1) % n);
        slide_since = now;
      end
    endfunction

    function void note_event(slide_event_t ev);
      int unsigned n;
      slide_view_t v;
      n = live_slides();
      case (ev.op)
        OP_TICK: advance_clock(ev.attract, ev.now);
        OP_ACTIVITY: begin
          running = 1'b1;
          quiet_since = ev.now;
          if (shown) begin
            shown = 1'b0;
            pointer = '0;
            paused = 1'b0;
          end
        end
        OP_NEXT: if (n != 0) show_slide(shown ? (pointer + 1) % n : 0, ev.now);
        OP_PREV: if (n != 0) show_slide(shown ? (pointer + n - 1) % n : 0, ev.now);
        OP_PAUSE: if (shown) paused = !paused;
        OP_LOAD: begin
          durations[ev.num] = ev.dur;
          pointer = '0;
          shown = 1'b0;
        end
        default: ;
      endcase
      v.visible = shown;
      v.slide = pointer;
      v.held = paused;
      v.alpha = dim_level(ev.now);
      views_due.push_back(v);
    endfunction

    function void complain(string what, longint unsigned want, longint unsigned got);
      mismatches++;
      if (mismatches <= REPORT_CAP)
        $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
    endfunction

    function void check_view(slide_view_t got);
      slide_view_t want;
      if (views_due.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_CAP)
          $display("%0t: result with none due, expected nothing actual %0h", $time, got);
        return;
      end
      want = views_due.pop_front();
      if (got.visible !== want.visible) complain("visible", want.visible, got.visible);
      if (got.slide !== want.slide) complain("current_slide", want.slide, got.slide);
      if (got.held !== want.held) complain("held", want.held, got.held);
      if (got.alpha !== want.alpha) complain("dim_alpha", want.alpha, got.alpha);
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [MS_W-1:0]      cfg_data_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic [2:0]           op_i = '0;
  logic                 attract_i = 1'b0;
  logic [TIME_W-1:0]    now_ms_i = '0;
  logic [SLIDE_W-1:0]   slide_number_i = '0;
  logic [MS_W-1:0]      duration_value_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic                 visible_o;
  logic [SLIDE_W-1:0]   current_slide_o;
  logic                 held_o;
  logic [ALPHA_W-1:0]   dim_alpha_o;

  slideshow_scoreboard sb = new();
  logic [TIME_W-1:0]   clock_ms = '0;
  int                  send_idle_pct = 0;
  int                  recv_stall_pct = 0;
  int                  phase_no = -1;
  logic                holding = 1'b0;

  idle_slideshow_sequencer_core dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .op_i             (op_i),
    .attract_i        (attract_i),
    .now_ms_i         (now_ms_i),
    .slide_number_i   (slide_number_i),
    .duration_value_i (duration_value_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .visible_o        (visible_o),
    .current_slide_o  (current_slide_o),
    .held_o           (held_o),
    .dim_alpha_o      (dim_alpha_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || holding) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) sb.write_reg(cfg_index_i, cfg_data_i);
      if (in_valid_i && in_ready_o)
        sb.note_event({op_i, attract_i, now_ms_i, slide_number_i, duration_value_i});
      if (out_valid_o && out_ready_i)
        sb.check_view({visible_o, current_slide_o, held_o, dim_alpha_o});
    end
  end

  // long output stall while the sender keeps offering
  initial begin
    wait (phase_no == 2);
    repeat (50) @(posedge clk_i);
    holding <= 1'b1;
    repeat (HOLDOFF_CYCLES) @(posedge clk_i);
    holding <= 1'b0;
  end

  initial begin
    #4000000;
    $display("[idle_slideshow_sequencer_core] ERROR");
    $finish;
  end

  task automatic send_event(slide_event_t ev);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    op_i             <= ev.op;
    attract_i        <= ev.attract;
    now_ms_i         <= ev.now;
    slide_number_i   <= ev.num;
    duration_value_i <= ev.dur;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic send_directed(logic [2:0] op, logic attract, logic [TIME_W-1:0] now,
                               logic [SLIDE_W-1:0] num = '0, logic [MS_W-1:0] dur = '0);
    send_event({op, attract, now, num, dur});
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.views_due.size() != 0);
  endtask

  task automatic cfg_transfer(iss_cfg_e idx, logic [MS_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic program_regs(logic [MS_W-1:0] idle, logic [MS_W-1:0] fade,
                              logic [COUNT_W-1:0] count);
    cfg_transfer(CFG_IDLE_MS, idle);
    cfg_transfer(CFG_FADE_MS, fade);
    cfg_transfer(CFG_SLIDE_COUNT, MS_W'(count));
    cfg_valid_i <= 1'b0;
  endtask

  function automatic slide_event_t random_event();
    slide_event_t ev;
    int unsigned pick;
    pick = $urandom_range(99);
    ev.attract = ($urandom_range(9) != 0);
    ev.num = SLIDE_W'($urandom);
    ev.dur = $urandom;
    if (pick < 60) ev.op = OP_TICK;
    else if (pick < 67) ev.op = OP_ACTIVITY;
    else if (pick < 75) ev.op = OP_NEXT;
    else if (pick < 82) ev.op = OP_PREV;
    else if (pick < 90) ev.op = OP_PAUSE;
    else if (pick < 97) ev.op = OP_LOAD;
    else ev.op = $urandom_range(1) ? OP_SPARE_A : OP_SPARE_B;
    if (ev.op == OP_LOAD) begin
      case ($urandom_range(9))
        0: ev.dur = '0;
        1: ;
        default: ev.dur = $urandom_range(150);
      endcase
    end
    case ($urandom_range(49))
      0: clock_ms = TIME_W'({$urandom, $urandom});
      1, 2: clock_ms = clock_ms + $urandom_range(1000);
      default: clock_ms = clock_ms + $urandom_range(25);
    endcase
    ev.now = clock_ms;
    return ev;
  endfunction

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty show, hide with attract off, then load durations near the top of the time range
    send_directed(OP_TICK, 1'b1, WRAP_BASE);
    send_directed(OP_NEXT, 1'b1, WRAP_BASE + 1);
    send_directed(OP_PREV, 1'b0, WRAP_BASE + 2);
    send_directed(OP_TICK, 1'b0, WRAP_BASE + 3);
    send_directed(OP_LOAD, 1'b0, WRAP_BASE + 4, 3'd0, 32'd12);
    send_directed(OP_LOAD, 1'b0, WRAP_BASE + 4, 3'd1, 32'd0);
    send_directed(OP_LOAD, 1'b0, WRAP_BASE + 5, 3'd2, 32'd20);
    send_directed(OP_LOAD, 1'b0, WRAP_BASE + 5, 3'd3, 32'd16);
    send_directed(OP_LOAD, 1'b0, WRAP_BASE + 6, 3'd4, 32'd25);
    send_directed(OP_LOAD, 1'b0, WRAP_BASE + 6, 3'd5, 32'd10);
    send_directed(OP_LOAD, 1'b0, WRAP_BASE + 7, 3'd6, 32'd18);
    send_directed(OP_LOAD, 1'b0, WRAP_BASE + 7, 3'd7, 32'hFFFF_FFFF);
    settle();
    program_regs(32'd10, 32'd8, 4'd15);
    // show on idle, fade, pause across the time wrap, advances and index wrap
    send_directed(OP_TICK, 1'b1, WRAP_BASE + 13);
    send_directed(OP_TICK, 1'b1, WRAP_BASE + 16);
    send_directed(OP_PAUSE, 1'b1, WRAP_BASE + 17);
    send_directed(OP_TICK, 1'b1, 48'd40);
    send_directed(OP_PAUSE, 1'b1, 48'd41);
    send_directed(OP_TICK, 1'b1, 48'd42);
    send_directed(OP_TICK, 1'b1, 48'd43);
    send_directed(OP_NEXT, 1'b1, 48'd44);
    send_directed(OP_PREV, 1'b1, 48'd45);
    send_directed(OP_PREV, 1'b1, 48'd46);
    send_directed(OP_PREV, 1'b1, 48'd47);
    send_directed(OP_TICK, 1'b1, 48'd49);
    send_directed(OP_ACTIVITY, 1'b1, 48'd50);
    send_directed(OP_SPARE_A, 1'b1, 48'd51);
    send_directed(OP_SPARE_B, 1'b0, 48'd52);
    send_directed(OP_PAUSE, 1'b1, 48'd53);
    clock_ms = 48'd60;

    for (int p = 0; p < PHASE_COUNT; p++) begin
      settle();
      phase_no = p;
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
        default: begin send_idle_pct = 9; recv_stall_pct = 9; end
      endcase
      case (p)
        0: program_regs(32'd50, 32'd30, 4'd8);
        1: program_regs(32'd0, 32'd0, 4'd3);
        2: program_regs(32'd20, 32'd100, 4'd8);
        3: program_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd1);
        4: program_regs(32'd30, 32'd25, 4'd15);
        5: program_regs(32'd5, 32'd60, 4'd0);
        6: program_regs(32'd100, 32'd10, 4'd5);
        default: program_regs(32'd40, 32'd40, 4'd2);
      endcase
      repeat (ITEMS_PER_PHASE) send_event(random_event());
    end

    settle();
    repeat (40) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("[idle_slideshow_sequencer_core] OK");
    end else begin
      $display("[idle_slideshow_sequencer_core] ERROR");
    end
    $finish;
  end
endmodule

FILE: filelist.f
+incdir+rtl
rtl/iss_pkg.sv
rtl/iss_dur_ram.sv
rtl/iss_alpha_div.sv
rtl/idle_slideshow_sequencer_core.sv
rtl/iss_checker.sv
bench/testbench.sv
